>>> hw/rtl/liu_pkg.sv
// ----------------------------------------------------------------------------
// liu_pkg: shared definitions for the linear interpolation upsampler
// Widths, reset values, sequencer states and the conditional-subtract result.
// ----------------------------------------------------------------------------
`default_nettype none

package liu_pkg;

  localparam int DATA_W = 8;   // key point and sample width
  localparam int LEN_W  = 6;   // segment length register width
  localparam int ACC_W  = LEN_W + 1;  // operand width of the shared subtractor

  localparam int                 MAX_SEGMENT_LEN_DEF = 63;
  localparam logic [LEN_W-1:0]   SEGMENT_LEN_RST     = 6'd8;

  // Sequencer states, one-hot.
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_ADJ  = 5'b00100,
    ST_EMIT = 5'b01000,
    ST_FIN  = 5'b10000
  } liu_state_t;

  // Result of the shared compare-and-subtract unit.
  typedef struct packed {
    logic             ge;    // operand was at least the divisor
    logic [ACC_W-1:0] res;   // operand, reduced by the divisor when ge is set
  } liu_csub_t;

endpackage

`default_nettype wire

>>> hw/rtl/linear_interp_upsampler.sv
// ----------------------------------------------------------------------------
// linear_interp_upsampler: key point to linear segment upsampler
// Expands each key point into a segment of samples that runs from the
// previous key point toward the new one, with exact integer flooring.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid / in_ready    in_key_value, in_final_point
//   out      output     out_valid / out_ready  out_sample, out_run_last,
//                                              out_stream_last
//   cfg      input      cfg_wr_en              cfg_wr_data (segment length)
//
// An input word is taken while the sequencer is idle. When a previous point
// exists and the segment length is two or more, the step per sample is found
// by a restoring division and a sign fix-up step, after which one sample word
// leaves per cycle while the output is not stalled; a final point adds one
// closing sample. The shared compare-and-subtract unit runs the division one
// quotient bit a cycle, then the remainder carry per sample.
// Reset (rst_n low, synchronous) forgets the previous point and sets the
// segment length to 8. A stalled output holds the sending states; the output
// register lets one sample wait while the next one is being formed.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_interp_upsampler
  import liu_pkg::*;
#(
  parameter int MAX_SEGMENT_LEN = MAX_SEGMENT_LEN_DEF
)
(
  input  wire  logic              clk,
  input  wire  logic              rst_n,

  input  wire  logic              cfg_wr_en,
  input  wire  logic [LEN_W-1:0]  cfg_wr_data,

  input  wire  logic              in_valid,
  output logic                    in_ready,
  input  wire  logic [DATA_W-1:0] in_key_value,
  input  wire  logic              in_final_point,

  output logic                    out_valid,
  input  wire  logic              out_ready,
  output logic [DATA_W-1:0]       out_sample,
  output logic                    out_run_last,
  output logic                    out_stream_last
);

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_SEGMENT_LEN);

  // Configuration and stream state.
  logic [LEN_W-1:0]  seg_len_r;
  logic [DATA_W-1:0] prev_r, prev_nxt;
  logic              have_prev_r, have_prev_nxt;
  liu_state_t        state_r, state_nxt;

  // Working registers of the current word.
  logic [DATA_W-1:0] cur_r, cur_nxt;
  logic              fin_r, fin_nxt;
  logic [LEN_W-1:0]  den_r, den_nxt;      // segment length minus one
  logic [LEN_W-1:0]  cnt_r, cnt_nxt;      // samples still to send after this one
  logic [DATA_W-1:0] dvd_r, dvd_nxt;      // dividend, shifts into the quotient
  logic [LEN_W-1:0]  rem_r, rem_nxt;      // division remainder
  logic [2:0]        bit_r, bit_nxt;      // quotient bits left after this one
  logic              neg_r, neg_nxt;      // the difference was negative
  logic [DATA_W-1:0] dq_r, dq_nxt;        // floored whole step per sample
  logic [LEN_W-1:0]  dr_r, dr_nxt;        // fractional step in units of 1/den
  logic [DATA_W-1:0] smp_r, smp_nxt;      // current sample value
  logic [LEN_W-1:0]  frac_r, frac_nxt;    // current fraction, below den

  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_sample_r, out_sample_nxt;
  logic              out_run_last_r, out_run_last_nxt;
  logic              out_stream_last_r, out_stream_last_nxt;

  logic              in_fire;
  logic              slot_free;
  logic [LEN_W-1:0]  len_clamped;
  logic [DATA_W:0]   diff_full;
  logic [DATA_W-1:0] diff_abs;
  logic [ACC_W-1:0]  csub_opnd;
  liu_csub_t         csub_out;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  // A zero length counts as one; lengths above the maximum saturate.
  always_comb begin
    priority if (seg_len_r == '0) begin
      len_clamped = LEN_W'(1);
    end else if (seg_len_r > MAX_LEN) begin
      len_clamped = MAX_LEN;
    end else begin
      len_clamped = seg_len_r;
    end
  end

  assign diff_full = {1'b0, in_key_value} - {1'b0, prev_r};
  assign diff_abs  = diff_full[DATA_W] ? DATA_W'(-diff_full) : diff_full[DATA_W-1:0];

  // The single subtractor serves the division during ST_DIV and the
  // fraction carry while samples are sent.
  always_comb begin
    if (state_r == ST_DIV) begin
      csub_opnd = {rem_r, dvd_r[DATA_W-1]};
    end else begin
      csub_opnd = ACC_W'(frac_r) + ACC_W'(dr_r);
    end
  end

  liu_csub u_csub (
    .opnd   (csub_opnd),
    .dvsr   (den_r),
    .result (csub_out)
  );

  always_comb begin
    state_nxt           = state_r;
    prev_nxt            = prev_r;
    have_prev_nxt       = have_prev_r;
    cur_nxt             = cur_r;
    fin_nxt             = fin_r;
    den_nxt             = den_r;
    cnt_nxt             = cnt_r;
    dvd_nxt             = dvd_r;
    rem_nxt             = rem_r;
    bit_nxt             = bit_r;
    neg_nxt             = neg_r;
    dq_nxt              = dq_r;
    dr_nxt              = dr_r;
    smp_nxt             = smp_r;
    frac_nxt            = frac_r;
    out_valid_nxt       = out_valid_r && !out_ready;
    out_sample_nxt      = out_sample_r;
    out_run_last_nxt    = out_run_last_r;
    out_stream_last_nxt = out_stream_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cur_nxt       = in_key_value;
          fin_nxt       = in_final_point;
          prev_nxt      = in_key_value;
          have_prev_nxt = !in_final_point;
          den_nxt       = len_clamped - LEN_W'(1);
          cnt_nxt       = len_clamped - LEN_W'(1);
          smp_nxt       = prev_r;
          frac_nxt      = '0;
          dvd_nxt       = diff_abs;
          neg_nxt       = diff_full[DATA_W];
          rem_nxt       = '0;
          bit_nxt       = 3'(DATA_W - 1);
          dq_nxt        = '0;
          dr_nxt        = '0;
          if (have_prev_r) begin
            // A one-sample segment carries only the start value.
            state_nxt = (len_clamped == LEN_W'(1)) ? ST_EMIT : ST_DIV;
          end else if (in_final_point) begin
            state_nxt = ST_FIN;
          end
        end
      end

      ST_DIV: begin
        rem_nxt = csub_out.res[LEN_W-1:0];
        dvd_nxt = {dvd_r[DATA_W-2:0], csub_out.ge};
        bit_nxt = bit_r - 3'd1;
        if (bit_r == '0) begin
          state_nxt = ST_ADJ;
        end
      end

      ST_ADJ: begin
        // Turn the magnitude quotient into a floored signed step.
        if (!neg_r) begin
          dq_nxt = dvd_r;
          dr_nxt = rem_r;
        end else if (rem_r == '0) begin
          dq_nxt = -dvd_r;
          dr_nxt = '0;
        end else begin
          dq_nxt = ~dvd_r;
          dr_nxt = den_r - rem_r;
        end
        state_nxt = ST_EMIT;
      end

      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt       = 1'b1;
          out_sample_nxt      = smp_r;
          out_run_last_nxt    = (cnt_r == '0) && !fin_r;
          out_stream_last_nxt = 1'b0;
          smp_nxt  = smp_r + dq_r + DATA_W'(csub_out.ge);
          frac_nxt = csub_out.res[LEN_W-1:0];
          cnt_nxt  = cnt_r - LEN_W'(1);
          if (cnt_r == '0) begin
            state_nxt = fin_r ? ST_FIN : ST_IDLE;
          end
        end
      end

      ST_FIN: begin
        if (slot_free) begin
          out_valid_nxt       = 1'b1;
          out_sample_nxt      = cur_r;
          out_run_last_nxt    = 1'b1;
          out_stream_last_nxt = 1'b1;
          state_nxt           = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seg_len_r   <= SEGMENT_LEN_RST;
      prev_r      <= '0;
      have_prev_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prev_r      <= prev_nxt;
      have_prev_r <= have_prev_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        seg_len_r <= cfg_wr_data;
      end
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk) begin
    cur_r             <= cur_nxt;
    fin_r             <= fin_nxt;
    den_r             <= den_nxt;
    cnt_r             <= cnt_nxt;
    dvd_r             <= dvd_nxt;
    rem_r             <= rem_nxt;
    bit_r             <= bit_nxt;
    neg_r             <= neg_nxt;
    dq_r              <= dq_nxt;
    dr_r              <= dr_nxt;
    smp_r             <= smp_nxt;
    frac_r            <= frac_nxt;
    out_sample_r      <= out_sample_nxt;
    out_run_last_r    <= out_run_last_nxt;
    out_stream_last_r <= out_stream_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_sample      = out_sample_r;
  assign out_run_last    = out_run_last_r;
  assign out_stream_last = out_stream_last_r;

endmodule

`default_nettype wire

>>> hw/rtl/liu_csub.sv
// ----------------------------------------------------------------------------
// liu_csub: shared compare-and-subtract unit
// Reduces an operand by the divisor when the operand is not below it.
// ----------------------------------------------------------------------------
`default_nettype none

module liu_csub
  import liu_pkg::*;
(
  input  wire logic [ACC_W-1:0] opnd,
  input  wire logic [LEN_W-1:0] dvsr,
  output liu_csub_t             result
);

  logic [ACC_W-1:0] dvsr_ext;
  logic [ACC_W-1:0] diff;

  assign dvsr_ext = {1'b0, dvsr};
  assign diff     = opnd - dvsr_ext;

  always_comb begin
    result.ge  = (opnd >= dvsr_ext);
    result.res = result.ge ? diff : opnd;
  end

endmodule

`default_nettype wire
